### src/cpvt_pkg.sv
// Shared types and constants for the change-point version table.
// Holds the controller states, the command and status structs and defaults.
// No dependencies.
package cpvt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int VER_W           = 16;
    localparam int POS_W           = 32;
    localparam int TUPLE_LEN       = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_WRITE,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST
    } t_idx_op;

    typedef enum logic [1:0] {
        RES_LOOKUP,
        RES_CHANGED,
        RES_NONE,
        RES_FULL
    } t_res;

    typedef struct packed {
        logic    ld_item;
        t_idx_op idx_op;
        logic    take_floor;
        logic    wr_shift;
        logic    wr_over;
        logic    wr_ins;
        logic    cnt_inc;
        logic    res_set;
        t_res    res;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_hit;
        logic scan_last;
        logic is_lookup;
        logic span_zero;
        logic floor_ver_eq;
        logic floor_tuple_eq;
        logic full;
        logic span_at_count;
        logic shift_done;
        logic out_busy;
    } t_status;

endpackage

### src/cpvt_ctrl.sv
// Sequencer for the version table: scan, decide, shift, write, respond.
// Drives the datapath through cpvt_pkg::t_cmd and reads cpvt_pkg::t_status.
// Depends on cpvt_pkg.
module cpvt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cpvt_pkg::t_status i_status,
    output cpvt_pkg::t_cmd   o_cmd
);
    import cpvt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.res  = RES_NONE;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    o_cmd.idx_op  = IDX_ZERO;
                    n_state = i_status.count_zero ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_hit) begin
                    o_cmd.take_floor = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = ST_DECIDE;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                    end
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_RESP;
                priority if (i_status.is_lookup) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_LOOKUP;
                end else if (!i_status.span_zero && i_status.floor_ver_eq) begin
                    o_cmd.wr_over = 1'b1;
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_CHANGED;
                end else if (!i_status.span_zero && i_status.floor_tuple_eq) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_NONE;
                end else if (i_status.full) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res     = RES_FULL;
                end else if (i_status.span_at_count) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.idx_op = IDX_LAST;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            ST_WRITE: begin
                o_cmd.wr_ins  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.res_set = 1'b1;
                o_cmd.res     = RES_CHANGED;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/cpvt_dpath.sv
// Datapath for the version table: entry memory, scan index, floor entry,
// entry count and the output register. Depends on cpvt_pkg.
module cpvt_dpath #(
    parameter int TABLE_DEPTH = cpvt_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = cpvt_pkg::DEF_COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cpvt_pkg::t_cmd             i_cmd,
    output cpvt_pkg::t_status          o_status,
    input  logic                       i_func,
    input  logic [cpvt_pkg::VER_W-1:0] i_version,
    input  logic [cpvt_pkg::POS_W-1:0] i_in_pos [cpvt_pkg::TUPLE_LEN],
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic                       o_ok,
    output logic                       o_table_full,
    output logic [cpvt_pkg::POS_W-1:0] o_out_pos [cpvt_pkg::TUPLE_LEN]
);
    import cpvt_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = COUNT_WIDTH;
    localparam int TW   = TUPLE_LEN * CW;
    localparam int RW   = VER_W + TW;

    logic [RW-1:0]    r_mem [TABLE_DEPTH];
    logic [RW-1:0]    r_rd_data;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    n_idx;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  r_span;
    logic [RW-1:0]    r_floor;
    logic             r_func;
    logic [VER_W-1:0] r_ver;
    logic [TW-1:0]    r_new;
    t_res             r_res;
    logic             r_out_valid;
    logic             r_ok;
    logic             r_full;
    logic [POS_W-1:0] r_pos [TUPLE_LEN];

    logic [TW-1:0]    new_t;
    logic [POS_W-1:0] floor_pos [TUPLE_LEN];
    logic [CNTW-1:0]  cnt_m1;
    logic [CNTW-1:0]  span_m1;
    logic [CNTW-1:0]  idx_ext;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [RW-1:0]    wr_data;
    logic             hit;

    for (genvar k = 0; k < TUPLE_LEN; k++) begin : g_tuple
        logic [CW+POS_W-1:0] in_ext;
        logic [CW+POS_W-1:0] fl_ext;
        assign in_ext = {{CW{1'b0}}, i_in_pos[k]};
        assign new_t[k*CW +: CW] = in_ext[CW-1:0];
        assign fl_ext = {{POS_W{1'b0}}, r_floor[k*CW +: CW]};
        assign floor_pos[k] = fl_ext[POS_W-1:0];
    end

    assign cnt_m1  = r_count - CNTW'(1);
    assign span_m1 = r_span - CNTW'(1);
    assign idx_ext = CNTW'(r_idx);

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_HOLD: n_idx = r_idx;
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = r_idx + AW'(1);
            IDX_DEC:  n_idx = r_idx - AW'(1);
            IDX_LAST: n_idx = cnt_m1[AW-1:0];
            default:  n_idx = r_idx;
        endcase
    end

    always_comb begin
        wr_en   = i_cmd.wr_shift | i_cmd.wr_over | i_cmd.wr_ins;
        wr_data = {r_ver, r_new};
        priority if (i_cmd.wr_shift) begin
            wr_addr = r_idx + AW'(1);
            wr_data = r_rd_data;
        end else if (i_cmd.wr_over) begin
            wr_addr = span_m1[AW-1:0];
        end else begin
            wr_addr = r_span[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign hit = (r_rd_data[RW-1 -: VER_W] <= r_ver);

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.ld_item) begin
            r_func <= i_func;
            r_ver  <= i_version;
            r_new  <= new_t;
            r_span <= '0;
        end else if (i_cmd.take_floor) begin
            r_floor <= r_rd_data;
            r_span  <= idx_ext + CNTW'(1);
        end
        if (i_cmd.res_set) begin
            r_res <= i_cmd.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ok   <= (r_res == RES_CHANGED) || ((r_res == RES_LOOKUP) && (r_span != '0));
            r_full <= (r_res == RES_FULL);
            for (int k = 0; k < TUPLE_LEN; k++) begin
                r_pos[k] <= ((r_res == RES_LOOKUP) && (r_span != '0)) ? floor_pos[k] : '0;
            end
        end
    end

    always_comb begin
        o_status.count_zero     = (r_count == '0);
        o_status.scan_hit       = hit;
        o_status.scan_last      = ((idx_ext + CNTW'(1)) == r_count);
        o_status.is_lookup      = r_func;
        o_status.span_zero      = (r_span == '0);
        o_status.floor_ver_eq   = (r_floor[RW-1 -: VER_W] == r_ver);
        o_status.floor_tuple_eq = (r_floor[TW-1:0] == r_new);
        o_status.full           = (r_count == CNTW'(TABLE_DEPTH));
        o_status.span_at_count  = (r_span == r_count);
        o_status.shift_done     = (idx_ext == r_span);
        o_status.out_busy       = r_out_valid && i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_table_full = r_full;
    assign o_out_pos    = r_pos;

endmodule

### src/change_point_version_table_core.sv
// Change-point version table: sorted (version, tuple) store with floor lookup.
// Instantiates cpvt_ctrl and cpvt_dpath; depends on cpvt_pkg.
//
// Input channel: i_in_valid / o_in_stall carry one beat per request; i_func
// selects insert (0) or lookup (1) at i_version, with the tuple on
// i_in_pos_0..6 for an insert. Output channel: o_out_valid / i_out_stall
// carry one result beat per request: o_ok, o_table_full, o_out_pos_0..6.
// One request is in work at a time; o_in_stall is high from acceptance until
// its result is placed in the output register.
// The entry memory is walked one entry per cycle through its single
// read port, first to find the floor entry and, on an insert that adds an
// entry, again to move every later entry up one place.
// Reset empties the table at once (entry count cleared) and drops any
// pending result. While the receiver stalls, the result stays in the output
// register; the next request is still accepted and worked on, and its result
// waits until the register is free.
module change_point_version_table_core #(
    parameter int TABLE_DEPTH = cpvt_pkg::DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = cpvt_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_version,
    input  logic [31:0] i_in_pos_0,
    input  logic [31:0] i_in_pos_1,
    input  logic [31:0] i_in_pos_2,
    input  logic [31:0] i_in_pos_3,
    input  logic [31:0] i_in_pos_4,
    input  logic [31:0] i_in_pos_5,
    input  logic [31:0] i_in_pos_6,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic        o_table_full,
    output logic [31:0] o_out_pos_0,
    output logic [31:0] o_out_pos_1,
    output logic [31:0] o_out_pos_2,
    output logic [31:0] o_out_pos_3,
    output logic [31:0] o_out_pos_4,
    output logic [31:0] o_out_pos_5,
    output logic [31:0] o_out_pos_6
);
    import cpvt_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [POS_W-1:0] in_pos  [TUPLE_LEN];
    logic [POS_W-1:0] out_pos [TUPLE_LEN];

    assign in_pos[0] = i_in_pos_0;
    assign in_pos[1] = i_in_pos_1;
    assign in_pos[2] = i_in_pos_2;
    assign in_pos[3] = i_in_pos_3;
    assign in_pos[4] = i_in_pos_4;
    assign in_pos[5] = i_in_pos_5;
    assign in_pos[6] = i_in_pos_6;

    assign o_out_pos_0 = out_pos[0];
    assign o_out_pos_1 = out_pos[1];
    assign o_out_pos_2 = out_pos[2];
    assign o_out_pos_3 = out_pos[3];
    assign o_out_pos_4 = out_pos[4];
    assign o_out_pos_5 = out_pos[5];
    assign o_out_pos_6 = out_pos[6];

    cpvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cpvt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_version    (i_version),
        .i_in_pos     (in_pos),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_ok         (o_ok),
        .o_table_full (o_table_full),
        .o_out_pos    (out_pos)
    );

endmodule

### src/cpvt_checker.sv
// Port-level checks for change_point_version_table_core, with its bind.
// No package dependency.
module cpvt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_ok,
    input logic        o_table_full,
    input logic [31:0] o_out_pos_0,
    input logic [31:0] o_out_pos_1,
    input logic [31:0] o_out_pos_2,
    input logic [31:0] o_out_pos_3,
    input logic [31:0] o_out_pos_4,
    input logic [31:0] o_out_pos_5,
    input logic [31:0] o_out_pos_6
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_full_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_ok && o_table_full))
        else $error("refused insert reported as a change");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!o_ok || o_table_full) |->
            (o_out_pos_0 == '0) && (o_out_pos_1 == '0) && (o_out_pos_2 == '0) &&
            (o_out_pos_3 == '0) && (o_out_pos_4 == '0) && (o_out_pos_5 == '0) &&
            (o_out_pos_6 == '0))
        else $error("counts nonzero without a found entry");

endmodule

bind change_point_version_table_core cpvt_checker u_cpvt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_ok         (o_ok),
    .o_table_full (o_table_full),
    .o_out_pos_0  (o_out_pos_0),
    .o_out_pos_1  (o_out_pos_1),
    .o_out_pos_2  (o_out_pos_2),
    .o_out_pos_3  (o_out_pos_3),
    .o_out_pos_4  (o_out_pos_4),
    .o_out_pos_5  (o_out_pos_5),
    .o_out_pos_6  (o_out_pos_6)
);
